// File: design/skin_weight_top4_normalizer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the skin weight top-four normalizer
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SKIN_WEIGHT_TOP4_NORMALIZER_CORE_MACROS_SVH
`define SKIN_WEIGHT_TOP4_NORMALIZER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle property
`define SWT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// antecedent now, consequent in the next cycle
`define SWT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define SWT_ASSERT(lbl, prop, msg)
`define SWT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/swt4n_pkg.sv
// ----------------------------------------------------------------------------
// swt4n_pkg
// Types and constants shared by the skin weight top-four normalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swt4n_pkg;

	localparam int POINT_CAPACITY = 1024;
	localparam int ROW_AW         = $clog2(POINT_CAPACITY);
	localparam int KEPT           = 4;
	localparam int SLOT_W         = $clog2(KEPT);
	localparam int CFG_W          = 11;
	localparam int INDEX_W        = 16;
	localparam int BONE_W         = 16;
	localparam int WEIGHT_W       = 32;
	localparam int SHARE_W        = 17;
	localparam int SUM_W          = WEIGHT_W + SLOT_W;
	localparam int QUO_STEPS      = SHARE_W;
	localparam int STEP_W         = $clog2(QUO_STEPS);

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_FETCH,
		ST_SCAN,
		ST_UPDATE,
		ST_SUM,
		ST_RANK,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic [BONE_W-1:0]   bone;
		logic [WEIGHT_W-1:0] weight;
	} slot_t;

	typedef slot_t [KEPT-1:0] row_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic [INDEX_W-1:0]  point_index;
		logic [BONE_W-1:0]   bone;
		logic [WEIGHT_W-1:0] strength;
	} in_word_t;

	typedef struct packed {
		logic                status;
		logic [BONE_W-1:0]   bone_a;
		logic [BONE_W-1:0]   bone_b;
		logic [BONE_W-1:0]   bone_c;
		logic [BONE_W-1:0]   bone_d;
		logic [SHARE_W-1:0]  share_a;
		logic [SHARE_W-1:0]  share_b;
		logic [SHARE_W-1:0]  share_c;
		logic [SHARE_W-1:0]  share_d;
	} out_word_t;

	typedef struct packed {
		logic                start;
		logic [WEIGHT_W-1:0] dividend;
		logic [SUM_W-1:0]    divisor;
	} div_req_t;

endpackage

`default_nettype wire

// File: design/skin_weight_top4_normalizer_core.sv
// ----------------------------------------------------------------------------
// skin_weight_top4_normalizer_core
// Keeps the four strongest bone influences per control point and returns
// them strongest first with shares normalized to Q1.16.
// ----------------------------------------------------------------------------
// Read steps: fetch, sum, 6 pair compares, then 4 shares on the shared
//   divider; an empty row skips the divider.
// Throughput: one word in flight; the next is taken once the result is
//   registered, which waits while the previous result is still held.
// Reset: asynchronous, arst_n low; then a clearing pass over all 1024 rows, in_ready low.
`timescale 1ns / 1ps
`default_nettype none
`include "skin_weight_top4_normalizer_core_macros.svh"

module skin_weight_top4_normalizer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire swt4n_pkg::in_word_t           in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output swt4n_pkg::out_word_t               out_data,
	input  wire logic                          cfg_we,
	input  wire logic [swt4n_pkg::CFG_W-1:0]   cfg_wdata
);

	localparam int K = swt4n_pkg::KEPT;
	localparam int SW = swt4n_pkg::SLOT_W;

	swt4n_pkg::state_t                 state_q, state_d;
	logic [swt4n_pkg::CFG_W-1:0]       points_q;
	logic [swt4n_pkg::ROW_AW-1:0]      clr_cnt_q;
	logic                              out_valid_q;
	swt4n_pkg::out_word_t              out_q;

	// working registers
	logic [1:0]                        op_q;
	logic [swt4n_pkg::ROW_AW-1:0]      idx_q;
	logic [swt4n_pkg::BONE_W-1:0]      bone_in_q;
	logic [swt4n_pkg::WEIGHT_W-1:0]    strength_q;
	logic                              res_status_q;
	logic [K-1:0][swt4n_pkg::BONE_W-1:0]  res_bone_q;
	logic [K-1:0][swt4n_pkg::SHARE_W-1:0] res_share_q;
	swt4n_pkg::row_t                   row_q;
	logic [SW-1:0]                     k_q, weak_q, pi_q, pj_q;
	logic [K-1:0][SW-1:0]              rank_q;
	logic [swt4n_pkg::SUM_W-1:0]       sum_q;

	swt4n_pkg::row_t                   mem [swt4n_pkg::POINT_CAPACITY];

	logic                              in_accept;
	logic                              idx_ok;
	logic                              clr_last;
	logic [swt4n_pkg::WEIGHT_W-1:0]    cmp_a, cmp_b;
	logic                              cmp_lt;
	logic                              mem_we;
	logic [swt4n_pkg::ROW_AW-1:0]      mem_waddr;
	swt4n_pkg::row_t                   mem_wdata;
	logic                              out_load;
	logic [swt4n_pkg::WEIGHT_W-1:0]    weight_k;
	swt4n_pkg::div_req_t               div_req;
	logic                              div_done;
	logic [swt4n_pkg::SHARE_W-1:0]     div_quo;

	assign in_ready  = (state_q == swt4n_pkg::ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign idx_ok    = ({1'b0, in_data.point_index} <
	                    {{(swt4n_pkg::INDEX_W + 1 - swt4n_pkg::CFG_W){1'b0}}, points_q}) &&
	                   ({1'b0, in_data.point_index} <
	                    (swt4n_pkg::INDEX_W + 1)'(swt4n_pkg::POINT_CAPACITY));
	assign clr_last  = (clr_cnt_q == '1);
	assign weight_k  = row_q[k_q].weight;
	assign out_load  = (state_q == swt4n_pkg::ST_REPLY) && (!out_valid_q || out_ready);

	// shared comparator: weakest search, replace test and pairwise ranking
	always_comb begin
		unique case (state_q)
			swt4n_pkg::ST_SCAN: begin
				cmp_a = row_q[k_q].weight;
				cmp_b = row_q[weak_q].weight;
			end
			swt4n_pkg::ST_UPDATE: begin
				cmp_a = row_q[weak_q].weight;
				cmp_b = strength_q;
			end
			default: begin
				cmp_a = row_q[pi_q].weight;
				cmp_b = row_q[pj_q].weight;
			end
		endcase
	end
	assign cmp_lt = (cmp_a < cmp_b);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swt4n_pkg::ST_INIT: begin
				if (clr_last) state_d = swt4n_pkg::ST_IDLE;
			end
			swt4n_pkg::ST_IDLE: begin
				if (in_accept) begin
					unique case (in_data.operation)
						swt4n_pkg::OP_ADD: begin
							if (idx_ok && in_data.strength != '0) state_d = swt4n_pkg::ST_FETCH;
							else state_d = swt4n_pkg::ST_REPLY;
						end
						swt4n_pkg::OP_READ: begin
							state_d = idx_ok ? swt4n_pkg::ST_FETCH : swt4n_pkg::ST_REPLY;
						end
						swt4n_pkg::OP_CLEAR: state_d = swt4n_pkg::ST_CLEAR;
						default: state_d = swt4n_pkg::ST_REPLY;
					endcase
				end
			end
			swt4n_pkg::ST_CLEAR: begin
				if (clr_last) state_d = swt4n_pkg::ST_REPLY;
			end
			swt4n_pkg::ST_FETCH: begin
				state_d = (op_q == swt4n_pkg::OP_ADD) ? swt4n_pkg::ST_SCAN : swt4n_pkg::ST_SUM;
			end
			swt4n_pkg::ST_SCAN: begin
				if (k_q == SW'(K - 1)) state_d = swt4n_pkg::ST_UPDATE;
			end
			swt4n_pkg::ST_UPDATE: state_d = swt4n_pkg::ST_REPLY;
			swt4n_pkg::ST_SUM: begin
				if (k_q == SW'(K - 1)) state_d = swt4n_pkg::ST_RANK;
			end
			swt4n_pkg::ST_RANK: begin
				if (pi_q == SW'(K - 2) && pj_q == SW'(K - 1)) begin
					state_d = (sum_q == '0) ? swt4n_pkg::ST_REPLY : swt4n_pkg::ST_DIV_GO;
				end
			end
			swt4n_pkg::ST_DIV_GO: state_d = swt4n_pkg::ST_DIV_WAIT;
			swt4n_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = (k_q == SW'(K - 1)) ? swt4n_pkg::ST_REPLY : swt4n_pkg::ST_DIV_GO;
				end
			end
			swt4n_pkg::ST_REPLY: begin
				if (out_load) state_d = swt4n_pkg::ST_IDLE;
			end
			default: state_d = swt4n_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swt4n_pkg::ST_INIT;
			points_q    <= swt4n_pkg::CFG_W'(swt4n_pkg::POINT_CAPACITY);
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) points_q <= cfg_wdata;
			if (state_q == swt4n_pkg::ST_INIT || state_q == swt4n_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + swt4n_pkg::ROW_AW'(1);
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// row store: one write port, one registered read port
	always_comb begin
		mem_wdata = row_q;
		if (state_q == swt4n_pkg::ST_UPDATE) begin
			mem_we    = cmp_lt;
			mem_waddr = idx_q;
			mem_wdata[weak_q].weight = strength_q;
			mem_wdata[weak_q].bone   = bone_in_q;
		end else begin
			mem_we    = (state_q == swt4n_pkg::ST_INIT) || (state_q == swt4n_pkg::ST_CLEAR);
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (state_q == swt4n_pkg::ST_FETCH) row_q <= mem[idx_q];
	end

	assign div_req.start    = (state_q == swt4n_pkg::ST_DIV_GO);
	assign div_req.dividend = weight_k;
	assign div_req.divisor  = sum_q;

	swt4n_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q         <= in_data.operation;
			idx_q        <= in_data.point_index[swt4n_pkg::ROW_AW-1:0];
			bone_in_q    <= in_data.bone;
			strength_q   <= in_data.strength;
			res_status_q <= (in_data.operation == swt4n_pkg::OP_ADD ||
			                 in_data.operation == swt4n_pkg::OP_READ) && !idx_ok;
			res_bone_q   <= '0;
			res_share_q  <= '0;
		end
		unique case (state_q)
			swt4n_pkg::ST_FETCH: begin
				k_q    <= (op_q == swt4n_pkg::OP_ADD) ? SW'(1) : '0;
				weak_q <= '0;
				sum_q  <= '0;
				pi_q   <= '0;
				pj_q   <= SW'(1);
				rank_q <= '0;
			end
			swt4n_pkg::ST_SCAN: begin
				if (cmp_lt) weak_q <= k_q;
				k_q <= k_q + SW'(1);
			end
			swt4n_pkg::ST_SUM: begin
				sum_q <= sum_q + swt4n_pkg::SUM_W'(weight_k);
				k_q   <= k_q + SW'(1);
			end
			swt4n_pkg::ST_RANK: begin
				// earlier slot wins on equal weight
				if (cmp_lt) rank_q[pi_q] <= rank_q[pi_q] + SW'(1);
				else rank_q[pj_q] <= rank_q[pj_q] + SW'(1);
				if (pj_q == SW'(K - 1)) begin
					pi_q <= pi_q + SW'(1);
					pj_q <= pi_q + SW'(2);
				end else begin
					pj_q <= pj_q + SW'(1);
				end
				k_q <= '0;
			end
			swt4n_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					if (weight_k != '0) begin
						res_bone_q[rank_q[k_q]]  <= row_q[k_q].bone;
						res_share_q[rank_q[k_q]] <= div_quo;
					end
					k_q <= k_q + SW'(1);
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.status  <= res_status_q;
			out_q.bone_a  <= res_bone_q[0];
			out_q.bone_b  <= res_bone_q[1];
			out_q.bone_c  <= res_bone_q[2];
			out_q.bone_d  <= res_bone_q[3];
			out_q.share_a <= res_share_q[0];
			out_q.share_b <= res_share_q[1];
			out_q.share_c <= res_share_q[2];
			out_q.share_d <= res_share_q[3];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SWT_ASSERT(a_div_done_in_wait,
		div_done |-> state_q == swt4n_pkg::ST_DIV_WAIT,
		"divider done outside wait state")
	`SWT_ASSERT(a_rank_distinct,
		state_q == swt4n_pkg::ST_DIV_GO |->
		rank_q[0] != rank_q[1] && rank_q[0] != rank_q[2] && rank_q[0] != rank_q[3] &&
		rank_q[1] != rank_q[2] && rank_q[1] != rank_q[3] && rank_q[2] != rank_q[3],
		"slot ranks collide")
	`SWT_ASSERT(a_share_bound,
		state_q == swt4n_pkg::ST_DIV_GO |-> swt4n_pkg::SUM_W'(weight_k) <= sum_q,
		"weight exceeds sum")
	`SWT_ASSERT_NEXT(a_reply_lands,
		out_load, out_valid_q && state_q == swt4n_pkg::ST_IDLE,
		"result word not registered")

endmodule

`default_nettype wire

// File: design/swt4n_divider.sv
// ----------------------------------------------------------------------------
// swt4n_divider
// Restoring divider, one quotient bit per cycle: floor(w * 2^16 / sum) for
// w <= sum. Dividend and divisor must hold until done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swt4n_divider (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire swt4n_pkg::div_req_t            req,
	output logic                                done,
	output logic [swt4n_pkg::SHARE_W-1:0]       quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [swt4n_pkg::STEP_W-1:0]      step_q;
	logic [swt4n_pkg::SUM_W:0]         rem_q;
	logic [swt4n_pkg::SHARE_W-1:0]     quo_q;
	logic [swt4n_pkg::SUM_W:0]         trial;
	logic [swt4n_pkg::SUM_W:0]         divisor_x;
	logic                              ge;

	// first step takes w as is (quotient bit 16), later steps shift in zeros
	assign trial     = (step_q == '0) ? rem_q : {rem_q[swt4n_pkg::SUM_W-1:0], 1'b0};
	assign divisor_x = {1'b0, req.divisor};
	assign ge        = (trial >= divisor_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + swt4n_pkg::STEP_W'(1);
				if (step_q == swt4n_pkg::STEP_W'(swt4n_pkg::QUO_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {{(swt4n_pkg::SUM_W + 1 - swt4n_pkg::WEIGHT_W){1'b0}}, req.dividend};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - divisor_x) : trial;
			quo_q <= {quo_q[swt4n_pkg::SHARE_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: tb/tb_skin_weight_top4_normalizer_core.sv
// ----------------------------------------------------------------------------
// tb_skin_weight_top4_normalizer_core
// Drives add, read, clear and spare-code words into the top-four influence
// store under several point limits, predicts every reply in the bench and
// checks each reply field by field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_skin_weight_top4_normalizer_core;
	import swt4n_pkg::*;

	localparam logic [1:0] OP_NOP    = 2'd3;
	localparam int         HOT_NUM   = 6;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	in_word_t            in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_word_t           out_data;
	logic                cfg_we    = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;

	// bench copy of the store and the point limit
	logic [WEIGHT_W-1:0] kept_weight [POINT_CAPACITY*KEPT];
	logic [BONE_W-1:0]   kept_bone   [POINT_CAPACITY*KEPT];
	logic [CFG_W-1:0]    point_limit = 11'd1024;

	in_word_t            pending_words[$];
	out_word_t           expected_results[$];
	int unsigned         hot_points[HOT_NUM];
	int unsigned         error_count = 0;
	int unsigned         result_seq  = 0;
	int unsigned         send_gap    = 0;
	int unsigned         recv_gap    = 0;
	logic                send_next;
	logic                quiet_in    = 1'b0;
	logic                quiet_out   = 1'b0;

	skin_weight_top4_normalizer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned draw_wait(input logic quiet);
		return quiet ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic in_word_t make_word(input logic [1:0] op, input int unsigned idx,
			input int unsigned joint, input logic [WEIGHT_W-1:0] w);
		in_word_t r;
		r.operation   = op;
		r.point_index = idx[INDEX_W-1:0];
		r.bone        = joint[BONE_W-1:0];
		r.strength    = w;
		return r;
	endfunction

	task automatic queue_word(input in_word_t w);
		pending_words = {pending_words, w};
	endtask

	// Updates the bench store and returns the reply the block owes for this word.
	function automatic out_word_t predict_result(input in_word_t w);
		out_word_t           r;
		int unsigned         base;
		int unsigned         weakest;
		int                  j;
		logic [WEIGHT_W-1:0] sw [KEPT];
		logic [BONE_W-1:0]   sb [KEPT];
		logic [WEIGHT_W-1:0] kw;
		logic [BONE_W-1:0]   kb;
		logic [BONE_W-1:0]   ob [4];
		logic [SHARE_W-1:0]  os [4];
		logic [63:0]         total;
		logic [63:0]         quo;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			ob[i] = '0;
			os[i] = '0;
		end
		case (w.operation)
			OP_ADD, OP_READ: begin
				if (w.point_index >= point_limit || w.point_index >= POINT_CAPACITY) begin
					r.status = 1'b1;
				end else begin
					base = w.point_index * KEPT;
					if (w.operation == OP_ADD) begin
						if (w.strength != 0) begin
							weakest = 0;
							for (int k = 1; k < KEPT; k++)
								if (kept_weight[base+k] < kept_weight[base+weakest])
									weakest = k;
							if (w.strength > kept_weight[base+weakest]) begin
								kept_weight[base+weakest] = w.strength;
								kept_bone[base+weakest]   = w.bone;
							end
						end
					end else begin
						total = 0;
						for (int i = 0; i < KEPT; i++) begin
							sw[i] = kept_weight[base+i];
							sb[i] = kept_bone[base+i];
							total += sw[i];
						end
						if (total != 0) begin
							// stable sort, strongest first
							for (int i = 1; i < KEPT; i++) begin
								kw = sw[i];
								kb = sb[i];
								j  = i;
								while (j > 0 && sw[j-1] < kw) begin
									sw[j] = sw[j-1];
									sb[j] = sb[j-1];
									j--;
								end
								sw[j] = kw;
								sb[j] = kb;
							end
							for (int i = 0; i < 4 && i < KEPT; i++) begin
								if (sw[i] != 0) begin
									quo   = ({32'b0, sw[i]} << 16) / total;
									ob[i] = sb[i];
									os[i] = quo[SHARE_W-1:0];
								end
							end
						end
					end
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < POINT_CAPACITY*KEPT; i++) begin
					kept_weight[i] = '0;
					kept_bone[i]   = '0;
				end
			end
			default: ;
		endcase
		r.bone_a  = ob[0];
		r.bone_b  = ob[1];
		r.bone_c  = ob[2];
		r.bone_d  = ob[3];
		r.share_a = os[0];
		r.share_b = os[1];
		r.share_c = os[2];
		r.share_d = os[3];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR reply #%0d %s: got %0h, expected %0h", result_seq, what, got, want);
		error_count++;
	endtask

	task automatic check_result(input out_word_t got, input out_word_t want);
		if (got.status  !== want.status)  report_mismatch("status",  got.status,  want.status);
		if (got.bone_a  !== want.bone_a)  report_mismatch("bone_a",  got.bone_a,  want.bone_a);
		if (got.bone_b  !== want.bone_b)  report_mismatch("bone_b",  got.bone_b,  want.bone_b);
		if (got.bone_c  !== want.bone_c)  report_mismatch("bone_c",  got.bone_c,  want.bone_c);
		if (got.bone_d  !== want.bone_d)  report_mismatch("bone_d",  got.bone_d,  want.bone_d);
		if (got.share_a !== want.share_a) report_mismatch("share_a", got.share_a, want.share_a);
		if (got.share_b !== want.share_b) report_mismatch("share_b", got.share_b, want.share_b);
		if (got.share_c !== want.share_c) report_mismatch("share_c", got.share_c, want.share_c);
		if (got.share_d !== want.share_d) report_mismatch("share_d", got.share_d, want.share_d);
	endtask

	// Mostly adds and reads on a few hot points so rows fill up and tie.
	function automatic in_word_t random_word();
		in_word_t    w;
		int unsigned pick;
		int unsigned lim;
		lim  = (point_limit < POINT_CAPACITY) ? point_limit : POINT_CAPACITY;
		pick = $urandom_range(0, 99);
		if (pick < 62)      w.operation = OP_ADD;
		else if (pick < 93) w.operation = OP_READ;
		else if (pick < 98) w.operation = OP_NOP;
		else                w.operation = OP_CLEAR;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			w.point_index = hot_points[$urandom_range(0, HOT_NUM-1)];
		end else if (pick < 90) begin
			w.point_index = $urandom;
		end else begin
			case ($urandom_range(0, 3))
				0:       w.point_index = (lim > 0) ? lim - 1 : 0;
				1:       w.point_index = point_limit;
				2:       w.point_index = POINT_CAPACITY - 1;
				default: w.point_index = POINT_CAPACITY;
			endcase
		end
		w.bone = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 40)      w.strength = $urandom;
		else if (pick < 65) w.strength = $urandom_range(1, 4);
		else if (pick < 75) w.strength = '0;
		else if (pick < 80) w.strength = '1;
		else                w.strength = $urandom_range(1, 65535) << 8;
		return w;
	endfunction

	// sampled at the falling edge, when driver and monitor have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	task automatic set_points(input logic [CFG_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		point_limit = value;
	endtask

	// driver: one word at a time, random gap after each accepted word
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			send_next = in_valid;
			if (in_valid && in_ready) begin
				expected_results = {expected_results, predict_result(in_data)};
				send_next = 1'b0;
				send_gap  = draw_wait(quiet_in);
			end
			if (!send_next) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (pending_words.size() != 0) begin
					in_data   <= pending_words.pop_front();
					send_next = 1'b1;
				end
			end
			in_valid <= send_next;
		end
	end

	// monitor: checks each reply, then stalls for a random number of cycles
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				result_seq++;
				if (expected_results.size() == 0)
					report_mismatch("unexpected reply", out_data.status, 0);
				else
					check_result(out_data, expected_results.pop_front());
				recv_gap = draw_wait(quiet_out);
			end else if (recv_gap != 0) begin
				recv_gap--;
			end
			out_ready <= (recv_gap == 0);
		end
	end

	initial begin
		int unsigned limits [7];
		int unsigned counts [7];
		int unsigned lim;
		for (int i = 0; i < POINT_CAPACITY*KEPT; i++) begin
			kept_weight[i] = '0;
			kept_bone[i]   = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed words under the reset limit
		@(negedge clk);
		queue_word(make_word(OP_READ, 0, 0, 0));            // empty row
		queue_word(make_word(OP_ADD, 0, 16'h0011, 0));      // zero weight
		queue_word(make_word(OP_ADD, 0, 1, 32'h0001_0000));
		queue_word(make_word(OP_ADD, 0, 2, 32'h0001_0000));
		queue_word(make_word(OP_ADD, 0, 3, 32'h0000_8000));
		queue_word(make_word(OP_ADD, 0, 4, 32'h0000_8000));
		queue_word(make_word(OP_ADD, 0, 5, 32'h0000_8000)); // equal: kept wins
		queue_word(make_word(OP_ADD, 0, 6, 32'h0000_8001)); // lowest weak slot
		queue_word(make_word(OP_READ, 0, 0, 0));
		queue_word(make_word(OP_ADD, 1023, 16'hFFFF, '1));
		queue_word(make_word(OP_ADD, 1023, 16'h0000, '1));
		queue_word(make_word(OP_ADD, 1023, 16'h8000, '1));
		queue_word(make_word(OP_ADD, 1023, 16'h7FFF, '1));
		queue_word(make_word(OP_READ, 1023, 0, 0));         // widest sum
		queue_word(make_word(OP_ADD, 1022, 16'h1234, '1));
		queue_word(make_word(OP_READ, 1022, 0, 0));         // full share
		queue_word(make_word(OP_ADD, 1024, 16'h00FF, 32'h55));
		queue_word(make_word(OP_READ, 16'hFFFF, 0, 0));
		queue_word(make_word(OP_NOP, 16'hFFFF, 16'hFFFF, '1));
		queue_word(make_word(OP_CLEAR, 16'h0A5A, 16'hA5A5, 32'hDEAD_BEEF));
		queue_word(make_word(OP_READ, 1023, 0, 0));
		queue_word(make_word(OP_READ, 0, 0, 0));

		limits = '{2047, 1, 0, $urandom_range(2, 1023), 1024, 1023, $urandom_range(2, 1023)};
		counts = '{150, 60, 30, 150, 130, 60, 120};
		for (int ph = 0; ph < 7; ph++) begin
			// sender holds off here until every reply of the last phase is in
			set_points(limits[ph][CFG_W-1:0]);
			lim = (point_limit < POINT_CAPACITY) ? point_limit : POINT_CAPACITY;
			for (int h = 0; h < HOT_NUM; h++)
				hot_points[h] = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
			hot_points[0] = 0;
			if (lim > 0)
				hot_points[HOT_NUM-1] = lim - 1;
			@(negedge clk);
			quiet_in  = (ph == 3) || ($urandom_range(0, 4) == 0);
			quiet_out = (ph == 3) || ($urandom_range(0, 4) == 0);
			for (int n = 0; n < counts[ph]; n++)
				queue_word(random_word());
		end

		wait_drained();
		repeat (120) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
